// ----- rtl/rcsm_pkg.sv -----
`default_nettype none
package rcsm_pkg;

  localparam int SLOT_COUNT_DEF    = 16;
  localparam int OBJECT_COUNT_DEF  = 64;
  localparam int PENDING_DEPTH_DEF = 32;
  localparam int MAX_RESULTS       = 32;

  localparam int ID_W  = 6;
  localparam int CNT_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic [1:0] OP_REASSIGN    = 2'd0;
  localparam logic [1:0] OP_COLLECT     = 2'd1;
  localparam logic [1:0] OP_RELEASE_ALL = 2'd2;

  typedef struct packed {
    logic [1:0]      operation;
    logic [3:0]      slot_index;
    logic [ID_W-1:0] object_id;
    logic            object_present;
  } in_item_t;

  typedef struct packed {
    logic            freed_valid;
    logic [ID_W-1:0] freed_object;
    logic            last_of_run;
    logic            overflow_seen;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/reference_count_slot_manager_unit.sv -----
// Reassign: a read-modify-write of the old count, then, unless the slot becomes empty, of the
// new count, on the one count memory port. Collect: a start step, then a read and an output
// step per pending entry; each result strobes on out_valid for one cycle, the cycle after it
// is formed, and the receiver cannot stall it. Release-all: a slot read, an old-count read
// and a decrement per slot, then a collect. Reset (synchronous, rst_n low) clears control
// state; a clearing pass then zeroes every count, busy high.
`default_nettype none
module reference_count_slot_manager_unit #(
  parameter int SLOT_COUNT    = rcsm_pkg::SLOT_COUNT_DEF,
  parameter int OBJECT_COUNT  = rcsm_pkg::OBJECT_COUNT_DEF,
  parameter int PENDING_DEPTH = rcsm_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rcsm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output rcsm_pkg::out_item_t      out_item
);

  import rcsm_pkg::*;

  // Capacity of the pending list: no collect may carry more than MAX_RESULTS.
  localparam int PEND_CAP = (PENDING_DEPTH < MAX_RESULTS) ? PENDING_DEPTH : MAX_RESULTS;
  localparam int SLOT_AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OBJ_AW   = $clog2(OBJECT_COUNT);
  localparam int PEND_AW  = (PEND_CAP > 1) ? $clog2(PEND_CAP) : 1;
  localparam int PC_W     = $clog2(PEND_CAP + 1);

  // Sequencer codes.
  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_RD_SLOT   = 4'd2;
  localparam logic [3:0] S_RD_OLD    = 4'd3;
  localparam logic [3:0] S_DEC       = 4'd4;
  localparam logic [3:0] S_RD_NEW    = 4'd5;
  localparam logic [3:0] S_INC       = 4'd6;
  localparam logic [3:0] S_COL_START = 4'd7;
  localparam logic [3:0] S_COL_RD    = 4'd8;
  localparam logic [3:0] S_COL_OUT   = 4'd9;

  // Control registers.
  logic [3:0]            state_r, state_nxt;
  logic [OBJ_AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [SLOT_COUNT-1:0] slot_occ_r, slot_occ_nxt;
  logic [PC_W-1:0]       pend_cnt_r, pend_cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload registers of the transaction in flight.
  logic [SLOT_AW-1:0]    slot_cur_r, slot_cur_nxt;
  logic [ID_W-1:0]       obj_r, obj_nxt;
  logic                  present_r, present_nxt;
  logic                  release_r, release_nxt;
  logic [ID_W-1:0]       old_obj_r, old_obj_nxt;
  logic                  old_ok_r, old_ok_nxt;
  logic [PEND_AW-1:0]    col_idx_r, col_idx_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // Memory ports.
  logic                  slot_we;
  logic [SLOT_AW-1:0]    slot_raddr;
  logic [ID_W-1:0]       slot_rdata;
  logic                  cnt_we;
  logic [OBJ_AW-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]      cnt_wdata, cnt_rdata;
  logic                  pend_we;
  logic [ID_W-1:0]       pend_rdata;

  logic                  accept;
  logic                  slot_last;
  logic                  col_last;
  logic                  in_slot_ok;
  logic                  in_obj_ok;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign slot_last  = (slot_cur_r == SLOT_AW'(SLOT_COUNT - 1));
  assign col_last   = ((PC_W'(col_idx_r) + PC_W'(1)) == pend_cnt_r);
  assign in_slot_ok = (32'(in_item.slot_index) < 32'(SLOT_COUNT));
  assign in_obj_ok  = !in_item.object_present || (32'(in_item.object_id) < 32'(OBJECT_COUNT));

  // Slot read address: the incoming slot at accept, the walking slot otherwise.
  assign slot_raddr = (state_r == S_IDLE) ? SLOT_AW'(in_item.slot_index) : slot_cur_r;

  rcsm_ram #(.WIDTH(ID_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_cur_r),
    .wdata (present_r ? obj_r : '0),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  rcsm_ram #(.WIDTH(CNT_W), .DEPTH(OBJECT_COUNT)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rcsm_ram #(.WIDTH(ID_W), .DEPTH(PEND_CAP)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (PEND_AW'(pend_cnt_r)),
    .wdata (old_obj_r),
    .raddr (col_idx_r),
    .rdata (pend_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    slot_occ_nxt  = slot_occ_r;
    pend_cnt_nxt  = pend_cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    slot_cur_nxt  = slot_cur_r;
    obj_nxt       = obj_r;
    present_nxt   = present_r;
    release_nxt   = release_r;
    old_obj_nxt   = old_obj_r;
    old_ok_nxt    = old_ok_r;
    col_idx_nxt   = col_idx_r;
    out_item_nxt  = out_item_r;
    slot_we       = 1'b0;
    cnt_we        = 1'b0;
    cnt_waddr     = OBJ_AW'(obj_r);
    cnt_wdata     = cnt_rdata;
    cnt_raddr     = OBJ_AW'(obj_r);
    pend_we       = 1'b0;

    case (state_r)
      S_CLR: begin
        // Zero one count per cycle after reset.
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + OBJ_AW'(1);
        if (clr_idx_r == OBJ_AW'(OBJECT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            OP_REASSIGN: begin
              // Drop a transaction that names a slot or object out of range.
              if (in_slot_ok && in_obj_ok) begin
                slot_cur_nxt = SLOT_AW'(in_item.slot_index);
                obj_nxt      = in_item.object_id;
                present_nxt  = in_item.object_present;
                release_nxt  = 1'b0;
                state_nxt    = S_RD_OLD;
              end
            end
            OP_COLLECT: begin
              state_nxt = S_COL_START;
            end
            OP_RELEASE_ALL: begin
              slot_cur_nxt = '0;
              obj_nxt      = '0;
              present_nxt  = 1'b0;
              release_nxt  = 1'b1;
              state_nxt    = S_RD_SLOT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD_SLOT: begin
        // Slot memory read issued on slot_cur_r.
        state_nxt = S_RD_OLD;
      end

      S_RD_OLD: begin
        // Fetch the old object's count and overwrite the slot.
        old_obj_nxt = slot_rdata;
        old_ok_nxt  = slot_occ_r[slot_cur_r] && (32'(slot_rdata) < 32'(OBJECT_COUNT));
        cnt_raddr   = OBJ_AW'(slot_rdata);
        slot_we     = 1'b1;
        slot_occ_nxt[slot_cur_r] = present_r;
        state_nxt   = S_DEC;
      end

      S_DEC: begin
        cnt_waddr = OBJ_AW'(old_obj_r);
        cnt_wdata = cnt_rdata - CNT_W'(1);
        if (old_ok_r && (cnt_rdata != '0)) begin
          cnt_we = 1'b1;
          if (cnt_rdata == CNT_W'(1)) begin
            // Count reached zero: append to the pending list or flag overflow.
            if (pend_cnt_r < PC_W'(PEND_CAP)) begin
              pend_we      = 1'b1;
              pend_cnt_nxt = pend_cnt_r + PC_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        if (present_r) begin
          state_nxt = S_RD_NEW;
        end else if (release_r) begin
          if (slot_last) begin
            state_nxt = S_COL_START;
          end else begin
            slot_cur_nxt = slot_cur_r + SLOT_AW'(1);
            state_nxt    = S_RD_SLOT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RD_NEW: begin
        // Count read issued on obj_r; sees the decrement just written.
        state_nxt = S_INC;
      end

      S_INC: begin
        cnt_wdata = cnt_rdata + CNT_W'(1);
        cnt_we    = (cnt_rdata < COUNT_MAX);
        state_nxt = S_IDLE;
      end

      S_COL_START: begin
        col_idx_nxt = '0;
        if (pend_cnt_r == '0) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.freed_valid   = 1'b0;
          out_item_nxt.freed_object  = '0;
          out_item_nxt.last_of_run   = 1'b1;
          out_item_nxt.overflow_seen = ovf_r;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_COL_RD;
        end
      end

      S_COL_RD: begin
        state_nxt = S_COL_OUT;
      end

      S_COL_OUT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.freed_valid   = 1'b1;
        out_item_nxt.freed_object  = pend_rdata;
        out_item_nxt.last_of_run   = col_last;
        out_item_nxt.overflow_seen = ovf_r;
        if (col_last) begin
          pend_cnt_nxt = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          col_idx_nxt = col_idx_r + PEND_AW'(1);
          state_nxt   = S_COL_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      slot_occ_r  <= '0;
      pend_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      slot_occ_r  <= slot_occ_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_cur_r <= slot_cur_nxt;
    obj_r      <= obj_nxt;
    present_r  <= present_nxt;
    release_r  <= release_nxt;
    old_obj_r  <= old_obj_nxt;
    old_ok_r   <= old_ok_nxt;
    col_idx_r  <= col_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // A result only follows a collect step of the sequencer.
  a_out_from_collect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_COL_OUT || state_r == S_COL_START))
    else $error("result strobe outside a collect");

  // An invalid result is always the single, final result of an empty collect.
  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.freed_valid |-> out_item.last_of_run)
    else $error("invalid result not marked last");

  // The final result of a collect leaves the list and the flag cleared.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_of_run |-> (pend_cnt_r == '0) && !ovf_r)
    else $error("pending list not emptied by collect");

  // The pending count never passes the list capacity.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= PC_W'(PEND_CAP))
    else $error("pending count beyond capacity");

endmodule
`default_nettype wire

// ----- rtl/rcsm_ram.sv -----
`default_nettype none
module rcsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
